/* design/bca_pkg.sv */
// Shared constants, types and a helper function for the binary to ASCII digit converter.
package bca_pkg;

   localparam int VALUE_WIDTH = 64;
   // Decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1.
   localparam int DIGITS      = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int DIGIT_BITS  = DIGITS * 4;
   localparam int DIG_IDX_W   = $clog2(DIGITS);
   localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
   localparam int QDEPTH      = 2;

   localparam logic       MODE_DEC   = 1'b0;
   localparam logic       MODE_HEX   = 1'b1;
   localparam logic [6:0] ASCII_ZERO = 7'h30;
   localparam logic [6:0] ASCII_A    = 7'h41;
   localparam logic [3:0] DEC_MAX    = 4'd9;
   localparam logic [3:0] DEC_BASE   = 4'd10;
   localparam logic [3:0] DABBLE_MIN = 4'd5;
   localparam logic [3:0] DABBLE_ADD = 4'd3;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_CONV,
      FR_PUSH
   } front_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } back_state_type;

   // One converted number waiting for output: BCD digits (the raw low byte in hex mode), digit 0 least significant.
   typedef struct packed {
      logic                  hex;
      logic [DIGIT_BITS-1:0] digits;
   } bca_entry_type;

   function automatic logic [6:0] bca_ascii(input logic [3:0] d);
      logic [3:0] off;
      off = d - DEC_BASE;
      if (d > DEC_MAX) begin
         return ASCII_A + {3'b000, off};
      end
      return ASCII_ZERO + {3'b000, d};
   endfunction

endpackage

/* design/bca_if.sv */
// Valid/ready channel interfaces for number requests and character responses.
interface bca_req_if import bca_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [VALUE_WIDTH-1:0] value;

   modport source(output valid, output mode, output value, input ready);
   modport sink(input valid, input mode, input value, output ready);
endinterface

interface bca_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       last;

   modport source(output valid, output character, output last, input ready);
   modport sink(input valid, input character, input last, output ready);
endinterface

/* design/bca_front.sv */
// Front end: takes a number, shift-and-add-3 BCD converts decimals, pushes digits.
module bca_front import bca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   bca_req_if.sink       req,
   output logic          push_valid,
   input  logic          push_ready,
   output bca_entry_type push_entry
);

   front_state_type        state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [DIGIT_BITS-1:0]  bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   hex_ff, hex_in;
   logic [DIGIT_BITS-1:0]  adj;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      hex_ff   <= hex_in;
   end

   // Add 3 to every digit of 5 or more before the shift.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= DABBLE_MIN) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + DABBLE_ADD;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      hex_in     = hex_ff;
      req.ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               hex_in   = req.mode;
               value_in = req.value;
               cnt_in   = BIT_CNT_W'(VALUE_WIDTH - 1);
               if (req.mode == MODE_HEX) begin
                  bcd_in      = '0;
                  bcd_in[7:0] = req.value[7:0];
                  state_in    = FR_PUSH;
               end else begin
                  bcd_in   = '0;
                  state_in = FR_CONV;
               end
            end
         end
         FR_CONV: begin
            bcd_in   = {adj[DIGIT_BITS-2:0], value_ff[VALUE_WIDTH-1]};
            value_in = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   assign push_entry.hex    = hex_ff;
   assign push_entry.digits = bcd_ff;

   a_conv_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FR_CONV && cnt_ff == '0) |=> state_ff == FR_PUSH)
      else $error("conversion did not finish after the last bit");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == FR_CONV || state_ff == FR_PUSH))
      else $error("accepted item did not start a conversion");

endmodule

/* design/bca_queue.sv */
// Two-entry queue of converted numbers between front and back ends.
module bca_queue import bca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  bca_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output bca_entry_type pop_entry
);

   localparam int PTR_W = $clog2(QDEPTH);
   localparam int CNT_W = $clog2(QDEPTH + 1);

   bca_entry_type         slot_ff [QDEPTH];
   bca_entry_type         slot_in [QDEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in;
   logic [PTR_W-1:0]      rd_ff, rd_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

   assign push_ready = (count_ff != CNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      slot_in  = slot_ff;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         slot_in[wr_ff] = push_entry;
         wr_in          = (wr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QDEPTH))
      else $error("queue occupancy out of range");

endmodule

/* design/bca_back.sv */
// Back end: walks the stored digits, drops leading zeros in decimal mode and emits one character per kept digit.
module bca_back import bca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  bca_entry_type pop_entry,
   bca_rsp_if.source     rsp
);

   back_state_type        state_ff, state_in;
   logic [DIGIT_BITS-1:0] digits_ff, digits_in;
   logic [DIG_IDX_W-1:0]  ptr_ff, ptr_in;
   logic                  started_ff, started_in;
   logic                  hex_ff, hex_in;
   logic                  out_valid_ff, out_valid_in;
   logic [6:0]            out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_free;
   logic [3:0]            cur_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      digits_ff   <= digits_in;
      ptr_ff      <= ptr_in;
      started_ff  <= started_in;
      hex_ff      <= hex_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign out_free  = !out_valid_ff || rsp.ready;
   assign cur_digit = digits_ff[{ptr_ff, 2'b00} +: 4];

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      ptr_in       = ptr_ff;
      started_in   = started_ff;
      hex_in       = hex_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      pop_ready    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               digits_in  = pop_entry.digits;
               hex_in     = pop_entry.hex;
               started_in = pop_entry.hex;
               ptr_in     = (pop_entry.hex == MODE_HEX) ? DIG_IDX_W'(1)
                                                        : DIG_IDX_W'(DIGITS - 1);
               state_in   = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               if (!started_ff && cur_digit == '0 && ptr_ff != '0) begin
                  // drop a leading zero
                  ptr_in = ptr_ff - 1'b1;
               end else begin
                  out_valid_in = 1'b1;
                  out_char_in  = bca_ascii(cur_digit);
                  out_last_in  = (ptr_ff == '0);
                  started_in   = 1'b1;
                  if (ptr_ff == '0) begin
                     state_in = BK_IDLE;
                  end else begin
                     ptr_in = ptr_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.character = out_char_ff;
   assign rsp.last      = out_last_ff;

   a_dec_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT && hex_ff == MODE_DEC) |-> cur_digit <= DEC_MAX)
      else $error("decimal digit out of range");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT && started_ff && out_free) |=> out_valid_ff)
      else $error("started run skipped a character");

endmodule

/* design/binary_to_ascii_digits.sv */
// Top level of the binary to ASCII digit converter.
// Each request carries a mode and a VALUE_WIDTH-bit value. In decimal mode the front end
// converts the value with a shift-and-add-3 loop that takes one input bit per cycle; a hex
// item gives two characters of the low byte and skips the loop. The front end takes no new
// request until it has pushed the current one. Converted digits wait in a two-entry queue,
// and the back end sends one character per cycle on the response channel while the receiver
// is ready, most significant first with last set on the final one, after dropping up to
// DIGITS - 1 leading zeros in decimal mode. Output runs overlap the next conversion, so the
// sustained decimal rate is set by the conversion loop. A decimal zero gives a single '0'.
module binary_to_ascii_digits import bca_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bca_req_if.sink   req_ch,
   bca_rsp_if.source rsp_ch
);

   logic          push_valid, push_ready;
   bca_entry_type push_entry;
   logic          pop_valid, pop_ready;
   bca_entry_type pop_entry;

   bca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   bca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   bca_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp_ch)
   );

endmodule

/* tb/tb_top.sv */
// Testbench for binary_to_ascii_digits: directed and random numbers, checked per character.
`timescale 1ns / 100ps

module tb_top import bca_pkg::*; ;

   localparam int RANDOM_ITEMS = 450;
   localparam int N_DIRECTED   = 21;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RADIX        = 10;
   localparam int MAX_DEC_NIB  = 9;
   localparam int MAX_RUN      = 20;

   typedef struct {
      logic        character_mode;
      logic [63:0] number;
      string       text;          // empty: expectation comes from the predictor
   } stim_row_type;

   typedef struct {
      logic [6:0] character;
      logic       last;
   } char_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bca_req_if req_ch ();
   bca_rsp_if rsp_ch ();

   binary_to_ascii_digits dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   char_result_type pending_chars [$];
   stim_row_type    directed_rows [N_DIRECTED];
   int              mismatch_count = 0;
   int              chars_checked  = 0;
   int              dec_items      = 0;
   int              hex_items      = 0;
   int              longest_run    = 0;
   int              cycle_count    = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [6:0] hex_digit_char(input logic [3:0] nib);
      if (nib > MAX_DEC_NIB) begin
         return ASCII_A + 7'(nib - RADIX);
      end
      return ASCII_ZERO + 7'(nib);
   endfunction

   // Queue the characters this number must produce.
   function automatic void predict_digit_run(input logic m, input logic [63:0] v);
      logic [3:0]  digits [MAX_RUN];
      logic [63:0] rest;
      int          n;
      if (m == MODE_HEX) begin
         pending_chars.push_back('{hex_digit_char(v[7:4]), 1'b0});
         pending_chars.push_back('{hex_digit_char(v[3:0]), 1'b1});
         hex_items++;
         return;
      end
      rest = v;
      n = 0;
      do begin
         digits[n] = 4'(rest % RADIX);
         rest = rest / RADIX;
         n++;
      end while (rest != 0);
      for (int k = 0; k < n; k++) begin
         pending_chars.push_back('{ASCII_ZERO + 7'(digits[n-1-k]), k == n - 1});
      end
      if (n > longest_run) longest_run = n;
      dec_items++;
   endfunction

   function automatic void queue_literal_text(input logic m, input string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_chars.push_back('{7'(text[i]), i == text.len() - 1});
      end
      if (m == MODE_HEX) hex_items++;
      else dec_items++;
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic send_number(input logic m, input logic [63:0] v, input string text);
      req_ch.valid <= 1'b1;
      req_ch.mode  <= m;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      if (text.len() != 0) queue_literal_text(m, text);
      else predict_digit_run(m, v);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] random_number();
      logic [63:0] full;
      logic [63:0] p;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return full >> $urandom_range(0, 63);
         1: begin
            // land next to a power of ten, where the digit count changes
            p = 64'd1;
            repeat ($urandom_range(0, 19)) p = p * RADIX;
            return p + 64'($urandom_range(0, 2)) - 64'd1;
         end
         2: return 64'($urandom_range(0, 999));
         3: return ~64'($urandom_range(0, 1000));
         default: return full;
      endcase
   endfunction

   // Receiver: ready follows a rotating pattern, reloaded now and then.
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   always @(posedge clock) begin
      rsp_ch.ready <= ready_pattern[0];
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern <= 16'hFFFF;
            1: ready_pattern <= 16'($urandom) | 16'h0001;
            2: ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
            default: ready_pattern <= (16'($urandom) & 16'($urandom) & 16'($urandom)) | 16'h8000;
         endcase
         pattern_age <= $urandom_range(16, 96);
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
         pattern_age <= pattern_age - 1;
      end
   end

   always @(posedge clock) begin
      char_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         chars_checked++;
         if (pending_chars.size() == 0) begin
            report_mismatch("unexpected item, character", rsp_ch.character, 0);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_ch.character !== want.character)
               report_mismatch("character", rsp_ch.character, want.character);
            if (rsp_ch.last !== want.last)
               report_mismatch("last", rsp_ch.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, pending_chars.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int items_sent;
      int burst_len;
      int gap;
      int calm_bursts;
      logic m;

      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_DEC;
      req_ch.value <= '0;

      directed_rows = '{
         '{MODE_DEC, 64'd0,                                 "0"},
         '{MODE_DEC, 64'hFFFF_FFFF_FFFF_FFFF,               "18446744073709551615"},
         '{MODE_DEC, 64'd9,                                 "9"},
         '{MODE_DEC, 64'd10,                                "10"},
         '{MODE_DEC, 64'd1,                                 ""},
         '{MODE_DEC, 64'd99,                                ""},
         '{MODE_DEC, 64'd100,                               ""},
         '{MODE_DEC, 64'd999999999999999999,                ""},
         '{MODE_DEC, 64'd1000000000000000000,               ""},
         '{MODE_DEC, 64'd9999999999999999999,               "9999999999999999999"},
         '{MODE_DEC, 64'd10000000000000000000,              "10000000000000000000"},
         '{MODE_DEC, 64'h8000_0000_0000_0000,               ""},
         '{MODE_DEC, 64'h7FFF_FFFF_FFFF_FFFF,               ""},
         '{MODE_DEC, 64'hAAAA_AAAA_AAAA_AAAA,               ""},
         '{MODE_DEC, 64'h5555_5555_5555_5555,               ""},
         '{MODE_HEX, 64'd0,                                 "00"},
         '{MODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF,               "FF"},
         '{MODE_HEX, 64'h0000_0000_0000_00A5,               ""},
         '{MODE_HEX, 64'h0123_4567_89AB_CD5A,               ""},
         '{MODE_HEX, 64'hFFFF_FFFF_FFFF_FF09,               ""},
         '{MODE_HEX, 64'hFEDC_BA98_7654_32F0,               ""}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_number(directed_rows[i].character_mode, directed_rows[i].number,
                     directed_rows[i].text);
         gap = $urandom_range(0, 3);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      drain_results();

      items_sent  = 0;
      calm_bursts = 0;
      while (items_sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 12);
         for (int b = 0; b < burst_len && items_sent < RANDOM_ITEMS; b++) begin
            m = ($urandom_range(0, 2) == 0) ? MODE_HEX : MODE_DEC;
            send_number(m, (m == MODE_HEX) ? {$urandom, $urandom} : random_number(), "");
            items_sent++;
            if (items_sent == RANDOM_ITEMS / 2) drain_results();
         end
         if (calm_bursts > 0) begin
            calm_bursts--;
            gap = 0;
         end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 7) == 0) calm_bursts = $urandom_range(3, 10);
         end
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d decimal and %0d hex numbers, %0d characters checked",
               dec_items, hex_items, chars_checked);
      $display("longest decimal run %0d digits, %0d cycles", longest_run, cycle_count);
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
